@@ hw/rtl/cgsa_pkg.sv @@
// Shared constants, types and codes of the charge grid scatter-accumulate unit.
package cgsa_pkg;

  // Grid geometry (power of two points per axis)
  localparam int GRID_MAX = 64;
  localparam int AXIS_W   = $clog2(GRID_MAX);
  localparam int CELLS    = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int CELL_W   = 3 * AXIS_W;

  // Field widths
  localparam int MODE_W       = 2;
  localparam int POS_W        = 20;
  localparam int CHARGE_W     = 16;
  localparam int CELL_RES_W   = 18;
  localparam int SUM_W        = 24;
  localparam int GRID_DIM_W   = 7;
  localparam int CELL_WIDTH_W = 14;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_DIM   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CELL_WIDTH = 2'd1;
  localparam logic [GRID_DIM_W-1:0]   GRID_DIM_RESET   = 7'd64;
  localparam logic [CELL_WIDTH_W-1:0] CELL_WIDTH_RESET = 14'd1229;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_DEPOSIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ_CLR = 2'd2;

  // Index datapath widths
  localparam int GD_W   = $clog2(GRID_MAX + 1);
  localparam int PROD_W = GD_W + CELL_WIDTH_W;
  localparam int NUM_W  = ((PROD_W > POS_W + 1) ? PROD_W : POS_W + 1) + 1;
  localparam int CNT_W  = $clog2(AXIS_W + 1);

  // Saturation bounds of a voxel sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_READ     = 2'd1,
    OP_READ_CLR = 2'd2,
    OP_SKIP     = 2'd3
  } op_t;

  typedef struct packed {
    op_t                          op;
    logic [CELL_RES_W-1:0]        voxel;
    logic signed [CHARGE_W-1:0]   charge;
  } qentry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [GRID_DIM_W-1:0]   grid_dim;
    logic [CELL_WIDTH_W-1:0] cell_width;
  } cfg_t;

endpackage

@@ hw/rtl/cgsa_ifs.sv @@
// Request, result and configuration channel interfaces.
interface cgsa_in_if;
  logic                                        valid;
  logic                                        ready;
  logic [cgsa_pkg::MODE_W-1:0]                 mode;
  logic signed [cgsa_pkg::POS_W-1:0]           pos_x;
  logic signed [cgsa_pkg::POS_W-1:0]           pos_y;
  logic signed [cgsa_pkg::POS_W-1:0]           pos_z;
  logic signed [cgsa_pkg::CHARGE_W-1:0]        atom_charge;
  logic [cgsa_pkg::CELL_RES_W-1:0]             read_cell;

  modport source(output valid, mode, pos_x, pos_y, pos_z, atom_charge, read_cell,
                 input ready);
  modport sink(input valid, mode, pos_x, pos_y, pos_z, atom_charge, read_cell,
               output ready);
endinterface

interface cgsa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [cgsa_pkg::CELL_RES_W-1:0]      cell_res;
  logic signed [cgsa_pkg::SUM_W-1:0]    cell_sum;
  logic                                 saturated;

  modport source(output valid, cell_res, cell_sum, saturated, input ready);
  modport sink(input valid, cell_res, cell_sum, saturated, output ready);
endinterface

interface cgsa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cgsa_pkg::CFG_ADDR_W-1:0]     addr;
  logic [cgsa_pkg::CFG_DATA_W-1:0]     data;

  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

@@ hw/rtl/cgsa_front.sv @@
// Front end: accepts requests, computes the voxel index of deposits, queues work.
module cgsa_front (
  input  logic                clk,
  input  logic                rst,
  cgsa_in_if.sink             item,
  input  cgsa_pkg::cfg_t      cfg,
  input  logic                clearing,
  input  cgsa_pkg::qstat_t    qstat,
  output logic                push,
  output cgsa_pkg::qentry_t   push_data
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_SETUP = 4'b0010,
    F_DIV   = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  fstate_t                                  state;
  cgsa_pkg::op_t                            op;
  logic [cgsa_pkg::CELL_RES_W-1:0]          rd_cell;
  logic signed [cgsa_pkg::CHARGE_W-1:0]     charge;
  logic signed [cgsa_pkg::POS_W-1:0]        pos [3];
  logic [cgsa_pkg::NUM_W-1:0]               rem [3];
  logic                                     neg [3];
  logic                                     ovf [3];
  logic [cgsa_pkg::AXIS_W-1:0]              quo [3];
  logic [cgsa_pkg::NUM_W-1:0]               dsh;
  logic [cgsa_pkg::CNT_W-1:0]               bcnt;
  logic [cgsa_pkg::PROD_W-1:0]              offset;

  logic [cgsa_pkg::GD_W-1:0]                g_eff;
  logic [cgsa_pkg::CELL_WIDTH_W-1:0]        cw_eff;
  logic [cgsa_pkg::CELL_WIDTH_W:0]          divisor;
  logic [cgsa_pkg::AXIS_W-1:0]              gm1;
  logic signed [cgsa_pkg::NUM_W-1:0]        num [3];
  logic                                     ge [3];
  logic [cgsa_pkg::AXIS_W-1:0]              idx [3];
  logic [cgsa_pkg::CELL_RES_W-1:0]          cell_dep;

  // Clamp the configured geometry into its usable range
  always_comb begin
    if (cfg.grid_dim == '0) begin
      g_eff = cgsa_pkg::GD_W'(1);
    end else if ((cgsa_pkg::GRID_DIM_W+1)'(cfg.grid_dim) >
                 (cgsa_pkg::GRID_DIM_W+1)'(cgsa_pkg::GRID_MAX)) begin
      g_eff = cgsa_pkg::GD_W'(cgsa_pkg::GRID_MAX);
    end else begin
      g_eff = cgsa_pkg::GD_W'(cfg.grid_dim);
    end
    cw_eff  = (cfg.cell_width == '0) ? cgsa_pkg::CELL_WIDTH_W'(1) : cfg.cell_width;
    divisor = {cw_eff, 1'b0};
    gm1     = cgsa_pkg::AXIS_W'(g_eff - cgsa_pkg::GD_W'(1));
  end

  // Numerator 2*coord + grid_dim*cell_width, quotient bit test, final clamp
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      num[a] = (cgsa_pkg::NUM_W'(pos[a]) <<< 1) + $signed(cgsa_pkg::NUM_W'(offset));
      ge[a]  = (rem[a] >= dsh);
      if (neg[a]) begin
        idx[a] = '0;
      end else if (ovf[a] || (quo[a] > gm1)) begin
        idx[a] = gm1;
      end else begin
        idx[a] = quo[a];
      end
    end
    cell_dep = cgsa_pkg::CELL_RES_W'(
      (32'(idx[0]) * cgsa_pkg::GRID_MAX + 32'(idx[1])) * cgsa_pkg::GRID_MAX + 32'(idx[2]));
  end

  assign item.ready = (state == F_IDLE) && !clearing;
  assign push       = (state == F_PUSH) && !qstat.full;

  always_comb begin
    push_data.op     = op;
    push_data.voxel  = (op == cgsa_pkg::OP_ADD) ? cell_dep : rd_cell;
    push_data.charge = charge;
  end

  // Offset product is registered and follows the configuration in the next cycle
  always_ff @(posedge clk) begin
    offset <= cgsa_pkg::PROD_W'(g_eff) * cgsa_pkg::PROD_W'(cw_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (item.valid && item.ready) begin
            pos[0]  <= item.pos_x;
            pos[1]  <= item.pos_y;
            pos[2]  <= item.pos_z;
            charge  <= item.atom_charge;
            rd_cell <= item.read_cell;
            if (item.mode == cgsa_pkg::MODE_DEPOSIT) begin
              op    <= cgsa_pkg::OP_ADD;
              state <= F_SETUP;
            end else begin
              if (32'(item.read_cell) >= 32'(cgsa_pkg::CELLS)) begin
                op <= cgsa_pkg::OP_SKIP;
              end else if (item.mode == cgsa_pkg::MODE_READ_CLR) begin
                op <= cgsa_pkg::OP_READ_CLR;
              end else begin
                op <= cgsa_pkg::OP_READ;
              end
              state <= F_PUSH;
            end
          end
        end
        F_SETUP: begin
          for (int a = 0; a < 3; a++) begin
            neg[a] <= num[a][cgsa_pkg::NUM_W-1];
            rem[a] <= num[a][cgsa_pkg::NUM_W-1] ? '0 : num[a];
            ovf[a] <= !num[a][cgsa_pkg::NUM_W-1] &&
                      (num[a] >= (cgsa_pkg::NUM_W'(divisor) << cgsa_pkg::AXIS_W));
            quo[a] <= '0;
          end
          dsh   <= cgsa_pkg::NUM_W'(divisor) << (cgsa_pkg::AXIS_W - 1);
          bcnt  <= cgsa_pkg::CNT_W'(cgsa_pkg::AXIS_W - 1);
          state <= F_DIV;
        end
        F_DIV: begin
          // one quotient bit per cycle on all three axes
          for (int a = 0; a < 3; a++) begin
            if (ge[a]) begin
              rem[a] <= rem[a] - dsh;
            end
            quo[a] <= (quo[a] << 1) | cgsa_pkg::AXIS_W'(ge[a]);
          end
          dsh  <= dsh >> 1;
          bcnt <= bcnt - cgsa_pkg::CNT_W'(1);
          if (bcnt == '0) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!qstat.full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/cgsa_queue.sv @@
// Short work queue between the front end and the voxel update engine.
module cgsa_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cgsa_pkg::qentry_t   push_data,
  input  logic                pop,
  output cgsa_pkg::qentry_t   head,
  output cgsa_pkg::qstat_t    qstat
);

  cgsa_pkg::qentry_t             entries [cgsa_pkg::QDEPTH];
  logic [cgsa_pkg::QPTR_W-1:0]   wr_ptr;
  logic [cgsa_pkg::QPTR_W-1:0]   rd_ptr;
  logic [cgsa_pkg::QCNT_W-1:0]   count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == cgsa_pkg::QCNT_W'(cgsa_pkg::QDEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + cgsa_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + cgsa_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + cgsa_pkg::QCNT_W'(1);
        2'b01:   count <= count - cgsa_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/cgsa_back.sv @@
// Back end: voxel store, clearing sweep, read-modify-write and result register.
module cgsa_back (
  input  logic                clk,
  input  logic                rst,
  input  cgsa_pkg::qentry_t   head,
  input  cgsa_pkg::qstat_t    qstat,
  output logic                pop,
  output logic                clearing,
  cgsa_out_if.source          result
);

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_WRITE = 3'b100
  } bstate_t;

  bstate_t                              state;
  cgsa_pkg::qentry_t                    cur;
  logic [cgsa_pkg::CELL_W-1:0]          clr_addr;
  logic signed [cgsa_pkg::SUM_W-1:0]    mem [cgsa_pkg::CELLS];
  logic signed [cgsa_pkg::SUM_W-1:0]    rd_data;

  logic signed [cgsa_pkg::SUM_W:0]      wide;
  logic signed [cgsa_pkg::SUM_W-1:0]    sum;
  logic                                 sat;
  logic                                 upd_we;
  logic signed [cgsa_pkg::SUM_W-1:0]    upd_data;
  logic                                 advance;
  logic                                 mem_we;
  logic [cgsa_pkg::CELL_W-1:0]          mem_waddr;
  logic signed [cgsa_pkg::SUM_W-1:0]    mem_wdata;

  assign clearing = (state == B_CLEAR);
  assign pop      = (state == B_IDLE) && !qstat.empty;
  assign advance  = (state == B_WRITE) && (!result.valid || result.ready);

  always_comb begin
    wide     = (cgsa_pkg::SUM_W+1)'(rd_data) + (cgsa_pkg::SUM_W+1)'(cur.charge);
    sum      = rd_data;
    sat      = 1'b0;
    upd_we   = 1'b0;
    upd_data = '0;
    case (cur.op)
      cgsa_pkg::OP_ADD: begin
        if (wide[cgsa_pkg::SUM_W] != wide[cgsa_pkg::SUM_W-1]) begin
          sat = 1'b1;
          sum = wide[cgsa_pkg::SUM_W] ? cgsa_pkg::SUM_MIN : cgsa_pkg::SUM_MAX;
        end else begin
          sum = wide[cgsa_pkg::SUM_W-1:0];
        end
        upd_we   = 1'b1;
        upd_data = sum;
      end
      cgsa_pkg::OP_READ: begin
        sum = rd_data;
      end
      cgsa_pkg::OP_READ_CLR: begin
        sum    = rd_data;
        upd_we = 1'b1;
      end
      default: begin
        sum = '0;
      end
    endcase
    mem_we    = clearing || (advance && upd_we);
    mem_waddr = clearing ? clr_addr : cur.voxel[cgsa_pkg::CELL_W-1:0];
    mem_wdata = clearing ? '0 : upd_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= mem[head.voxel[cgsa_pkg::CELL_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance) begin
      result.cell_res  <= cur.voxel;
      result.cell_sum  <= sum;
      result.saturated <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_CLEAR;
      clr_addr     <= '0;
      result.valid <= 1'b0;
    end else begin
      if (advance) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + cgsa_pkg::CELL_W'(1);
          if (clr_addr == cgsa_pkg::CELL_W'(cgsa_pkg::CELLS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop) begin
            state <= B_WRITE;
          end
        end
        B_WRITE: begin
          if (advance) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/charge_grid_scatter_accumulate_unit.sv @@
// Top level of the charge grid scatter-accumulate unit.
// A deposit request passes the index divider, which forms one quotient bit per cycle,
// then the queue and the read-modify-write; a read or read-and-clear skips the divider.
// The front end takes no new request until it has queued the previous one.
// Reset: synchronous, active high; afterwards a clearing pass writes zero to all
// 262144 voxels, one per cycle, and no request is accepted until it is done.
module charge_grid_scatter_accumulate_unit (
  input logic         clk,
  input logic         rst,
  cgsa_in_if.sink     item,
  cgsa_out_if.source  result,
  cgsa_cfg_if.sink    cfg
);

  // Config registers; the user must write them only while the unit is idle (not enforced)
  logic [cgsa_pkg::GRID_DIM_W-1:0]   grid_dim;
  logic [cgsa_pkg::CELL_WIDTH_W-1:0] cell_width;
  cgsa_pkg::cfg_t                    cfg_regs;

  // Front-to-back queue signals
  logic               push;
  cgsa_pkg::qentry_t  push_data;
  logic               pop;
  cgsa_pkg::qentry_t  head;
  cgsa_pkg::qstat_t   qstat;
  logic               clearing;

  // Always take configuration writes; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_dim   <= cgsa_pkg::GRID_DIM_RESET;
      cell_width <= cgsa_pkg::CELL_WIDTH_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        cgsa_pkg::REG_GRID_DIM:   grid_dim   <= cfg.data[cgsa_pkg::GRID_DIM_W-1:0];
        cgsa_pkg::REG_CELL_WIDTH: cell_width <= cfg.data[cgsa_pkg::CELL_WIDTH_W-1:0];
        default: begin
          grid_dim <= grid_dim;
        end
      endcase
    end
  end

  assign cfg_regs.grid_dim   = grid_dim;
  assign cfg_regs.cell_width = cell_width;

  // Front: classify requests, work out the voxel of each deposit
  cgsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg       (cfg_regs),
    .clearing  (clearing),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: decouple index computation from the store update
  cgsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // Back: one read-modify-write at a time, so no hazard on a repeated voxel
  cgsa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .clearing (clearing),
    .result   (result)
  );

  // No request slips in while the store is being cleared
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |-> !clearing)
    else $error("request accepted during clearing pass");

  // Queue status stays consistent
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty at once");

  // A saturated result carries a bound of the sum range
  a_sat_at_bound: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.saturated) |->
      (result.cell_sum == cgsa_pkg::SUM_MAX || result.cell_sum == cgsa_pkg::SUM_MIN))
    else $error("saturated result not at a bound");

  // Nothing is popped from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench of the charge grid scatter-accumulate unit.
`timescale 1ns / 1ps

module testbench;
  import cgsa_pkg::*;

  // Register index that maps to nothing; writes to it must leave both settings alone
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  // Mode code left over by the three real modes; it behaves as a plain read
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Idle cycles with no handshake at all before the run is declared hung.
  // It must also cover the clearing pass over all 262144 voxels after reset.
  localparam int WATCHDOG_LIMIT = 800_000;
  // Receiver hold-off long enough to fill the block and stall its input
  localparam int LONG_HOLD = 300;
  // Cycles to linger once every result is in
  localparam int DRAIN_CYCLES = 32;

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic signed [POS_W-1:0]    x;
    logic signed [POS_W-1:0]    y;
    logic signed [POS_W-1:0]    z;
    logic signed [CHARGE_W-1:0] q;
    logic [CELL_RES_W-1:0]      voxel;
  } request_t;

  typedef struct {
    logic [CELL_RES_W-1:0]   voxel;
    logic signed [SUM_W-1:0] sum;
    logic                    sat;
  } voxel_result_t;

  // Mirror of the voxel store and settings; predicts one result per request
  class voxel_sum_tracker;
    logic signed [SUM_W-1:0] voxel_sum [int];
    logic [GRID_DIM_W-1:0]   grid_dim;
    logic [CELL_WIDTH_W-1:0] cell_width;
    voxel_result_t           expected_sums [$];
    int                      touched [$];
    int                      errors;

    function new();
      grid_dim   = GRID_DIM_RESET;
      cell_width = CELL_WIDTH_RESET;
      errors     = 0;
    endfunction

    function int eff_dim();
      int g;
      g = grid_dim;
      if (g < 1) g = 1;
      if (g > GRID_MAX) g = GRID_MAX;
      return g;
    endfunction

    function int eff_width();
      return (cell_width == 0) ? 1 : int'(cell_width);
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == REG_GRID_DIM) grid_dim = data[GRID_DIM_W-1:0];
      else if (addr == REG_CELL_WIDTH) cell_width = data[CELL_WIDTH_W-1:0];
    endfunction

    function logic signed [SUM_W-1:0] stored(int c);
      return voxel_sum.exists(c) ? voxel_sum[c] : '0;
    endfunction

    // Nearest grid point along one axis, centered and clamped to the grid
    function int axis_cell(logic signed [POS_W-1:0] p, int g, int cw);
      longint num;
      longint q;
      num = 2 * longint'(p) + longint'(g) * longint'(cw);
      if (num < 0) return 0;
      q = num / (2 * longint'(cw));
      if (q > g - 1) q = g - 1;
      return int'(q);
    endfunction

    function void note_request(request_t r);
      voxel_result_t e;
      int g, cw, i, j, k, c;
      longint s;
      e.sat = 1'b0;
      if (r.mode == MODE_DEPOSIT) begin
        g  = eff_dim();
        cw = eff_width();
        i  = axis_cell(r.x, g, cw);
        j  = axis_cell(r.y, g, cw);
        k  = axis_cell(r.z, g, cw);
        c  = (i * GRID_MAX + j) * GRID_MAX + k;
        s  = longint'(stored(c)) + longint'(r.q);
        if (s > longint'(SUM_MAX)) begin
          s     = longint'(SUM_MAX);
          e.sat = 1'b1;
        end else if (s < longint'(SUM_MIN)) begin
          s     = longint'(SUM_MIN);
          e.sat = 1'b1;
        end
        e.voxel      = c[CELL_RES_W-1:0];
        e.sum        = s[SUM_W-1:0];
        voxel_sum[c] = e.sum;
        touched.push_back(c);
      end else begin
        c       = int'(r.voxel);
        e.voxel = r.voxel;
        e.sum   = stored(c);
        if (r.mode == MODE_READ_CLR) voxel_sum[c] = '0;
      end
      expected_sums.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic [CELL_RES_W-1:0] voxel, logic signed [SUM_W-1:0] sum, logic sat);
      voxel_result_t e;
      if (expected_sums.size() == 0) begin
        report($sformatf("result with nothing pending: cell %0d sum %0d", voxel, sum));
        return;
      end
      e = expected_sums.pop_front();
      if (voxel !== e.voxel)
        report($sformatf("cell_res %0d, predicted %0d", voxel, e.voxel));
      if (sum !== e.sum)
        report($sformatf("cell_sum %0d at cell %0d, predicted %0d", sum, e.voxel, e.sum));
      if (sat !== e.sat)
        report($sformatf("saturated %b at cell %0d, predicted %b", sat, e.voxel, e.sat));
    endtask

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  cgsa_in_if  item_ch();
  cgsa_out_if result_ch();
  cgsa_cfg_if cfg_ch();

  charge_grid_scatter_accumulate_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #1 clk = ~clk;

  voxel_sum_tracker tracker = new();

  // Both sides drop idle gaps while this is high, giving stretches at full rate
  bit eager = 1'b0;
  // Bumped by the stimulus to ask the receiver for one long hold-off
  int hold_asks = 0;

  // Mostly short gaps, now and then a long one
  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (eager) return 0;
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Coordinates spread over the grid in use, plus full-range noise and extremes
  function automatic logic signed [POS_W-1:0] pick_coord();
    int p, g, cw, span, v;
    p = $urandom_range(0, 99);
    if (p < 5) return $urandom_range(0, 1) ? {1'b0, {(POS_W-1){1'b1}}} : {1'b1, {(POS_W-1){1'b0}}};
    if (p < 15) return POS_W'($urandom());
    g    = tracker.eff_dim();
    cw   = tracker.eff_width();
    span = g * cw / 2 + 2 * cw;
    if (span > 524287) span = 524287;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v[POS_W-1:0];
  endfunction

  // A positive or negative lean pushes a voxel toward saturation
  function automatic logic signed [CHARGE_W-1:0] pick_charge(int lean);
    int p, v;
    p = $urandom_range(0, 99);
    if (lean > 0 && p < 75) begin
      v = $urandom_range(24000, 32767);
      return v[CHARGE_W-1:0];
    end
    if (lean < 0 && p < 75) begin
      v = -int'($urandom_range(24000, 32768));
      return v[CHARGE_W-1:0];
    end
    if (p < 88) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return CHARGE_W'($urandom());
  endfunction

  function automatic request_t make_req(logic [MODE_W-1:0] mode, int x, int y, int z, int q,
                                        int voxel);
    request_t r;
    r.mode  = mode;
    r.x     = x[POS_W-1:0];
    r.y     = y[POS_W-1:0];
    r.z     = z[POS_W-1:0];
    r.q     = q[CHARGE_W-1:0];
    r.voxel = voxel[CELL_RES_W-1:0];
    return r;
  endfunction

  // Some plain reads target voxels already deposited to, so sums are actually checked
  function automatic request_t random_request(int dep_pct, int lean, int clr_pct);
    request_t r;
    int p, rest;
    p       = $urandom_range(0, 99);
    rest    = p - dep_pct;
    r.x     = pick_coord();
    r.y     = pick_coord();
    r.z     = pick_coord();
    r.q     = pick_charge(lean);
    r.voxel = CELL_RES_W'($urandom());
    if (p < dep_pct) begin
      r.mode = MODE_DEPOSIT;
    end else begin
      if (rest < clr_pct) r.mode = MODE_READ_CLR;
      else if (rest < clr_pct + 4) r.mode = MODE_SPARE;
      else r.mode = MODE_READ;
      if (rest >= clr_pct + 10 && tracker.touched.size() > 0)
        r.voxel = CELL_RES_W'(tracker.touched[$urandom_range(0, tracker.touched.size() - 1)]);
    end
    return r;
  endfunction

  // Offer one request after a random gap; hold it until the block takes it
  task automatic offer_request(request_t r);
    int gap = rand_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.mode        <= r.mode;
    item_ch.pos_x       <= r.x;
    item_ch.pos_y       <= r.y;
    item_ch.pos_z       <= r.z;
    item_ch.atom_charge <= r.q;
    item_ch.read_cell   <= r.voxel;
    item_ch.valid       <= 1'b1;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    tracker.note_request(r);
  endtask

  // Drop the request valid and hold until every predicted result has come back
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  // Leaves valid high so a following write does not toggle it within one step
  task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    tracker.write_reg(addr, data);
  endtask

  // Settings change only with the block idle
  task automatic set_grid(int gd, int cw, bit poke_unused);
    logic [CFG_DATA_W-1:0] dim_word;
    drain_results();
    // Junk above the 7-bit grid size field must be ignored
    dim_word = {7'($urandom()), gd[GRID_DIM_W-1:0]};
    write_register(REG_GRID_DIM, dim_word);
    write_register(REG_CELL_WIDTH, cw[CELL_WIDTH_W-1:0]);
    if (poke_unused) write_register(REG_UNUSED, 14'($urandom()));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(int n, int dep_pct, int lean, int clr_pct, int hold_at,
                           int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_asks <= hold_asks + 1;
      // Sender pause: let the block drain completely mid-phase
      if (i == pause_at) drain_results();
      offer_request(random_request(dep_pct, lean, clr_pct));
    end
  endtask

  // Receiver: check every accepted result, then pick the next ready value
  initial begin
    int run_left;
    int idle_left;
    int hold_left;
    int hold_seen;
    run_left  = 0;
    idle_left = 0;
    hold_left = 0;
    hold_seen = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready)
        tracker.check_result(result_ch.cell_res, result_ch.cell_sum, result_ch.saturated);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        result_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left  = $urandom_range(1, 12);
          idle_left = rand_gap();
        end
      end
    end
  end

  // Watchdog: count cycles in which no channel moves anything
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int center;
    center = (32 * GRID_MAX + 32) * GRID_MAX + 32;

    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.mode        = MODE_DEPOSIT;
    item_ch.pos_x       = '0;
    item_ch.pos_y       = '0;
    item_ch.pos_z       = '0;
    item_ch.atom_charge = '0;
    item_ch.read_cell   = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.addr         = REG_GRID_DIM;
    cfg_ch.data         = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings (64 points, width 1229)
    // Far corner clamps to the last voxel; the near corner has a negative numerator
    offer_request(make_req(MODE_DEPOSIT, 524287, 524287, 524287, 32767, 0));
    offer_request(make_req(MODE_DEPOSIT, -524288, -524288, -524288, -32768, 262143));
    // Origin lands in the center voxel; add and cancel a tiny charge there
    offer_request(make_req(MODE_DEPOSIT, 0, 0, 0, 1, 0));
    offer_request(make_req(MODE_DEPOSIT, 0, 0, 0, -1, 262143));
    offer_request(make_req(MODE_DEPOSIT, 524287, -524288, 0, 0, 0));
    // Cell boundaries: exactly one width past center steps up one index
    offer_request(make_req(MODE_DEPOSIT, 1229, 1228, -39328, 4096, 0));
    offer_request(make_req(MODE_DEPOSIT, -39329, 39327, 1229, -4096, 0));
    offer_request(make_req(MODE_READ, -1, -1, -1, -1, center));
    offer_request(make_req(MODE_READ_CLR, 0, 0, 0, 0, 262143));
    offer_request(make_req(MODE_READ, -1, -1, -1, -1, 262143));
    // Spare mode reads without clearing
    offer_request(make_req(MODE_SPARE, 0, 0, 0, 0, 0));
    offer_request(make_req(MODE_READ, 0, 0, 0, 0, 0));
    offer_request(make_req(MODE_READ_CLR, 0, 0, 0, 0, 0));
    offer_request(make_req(MODE_READ, 0, 0, 0, 0, 0));
    offer_request(make_req(MODE_READ, 0, 0, 0, 0, 12345));
    offer_request(make_req(MODE_DEPOSIT, 524287, 524287, 524287, 32767, 0));
    offer_request(make_req(MODE_READ, 0, 0, 0, 0, 262143));

    // Full grid, default width; one long receiver hold-off to back up the input
    set_grid(64, 1229, 1'b0);
    run_phase(250, 60, 0, 10, 100, -1);

    // Grid size zero acts as one, width zero as one: every atom hits voxel 0
    // and a strong positive lean drives it into saturation
    set_grid(0, 0, 1'b0);
    run_phase(400, 90, 1, 1, -1, -1);

    // Single voxel again; clear it and drive it to the negative bound
    set_grid(1, $urandom_range(1, 16383), 1'b0);
    offer_request(make_req(MODE_READ_CLR, 0, 0, 0, 0, 0));
    run_phase(350, 92, -1, 0, -1, -1);

    // Smallest real grid, widest cells; also poke the unused register index
    set_grid(2, 16383, 1'b1);
    run_phase(150, 60, 0, 10, -1, 75);

    // Oversized grid size clamps to the maximum; narrowest cells
    set_grid(127, 1, 1'b0);
    run_phase(150, 60, 0, 10, -1, -1);

    // Random settings at full rate on both sides
    eager = 1'b1;
    set_grid($urandom_range(2, 64), $urandom_range(1, 16383), 1'b0);
    run_phase(150, 60, 0, 10, -1, -1);
    eager = 1'b0;

    set_grid(64, 16383, 1'b0);
    run_phase(150, 60, 0, 10, -1, -1);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
